@@ hdl/pidc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Types and constants shared by the PID controller with feedforward block.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MUL_A_W   = 32;
  localparam int unsigned MUL_B_W   = 64;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_N_W   = 33;
  localparam int unsigned DIV_D_W   = 32;
  localparam int unsigned TERM_MAG_W = 60;
  localparam int unsigned TERM_W     = TERM_MAG_W + 1;

  localparam logic [TERM_MAG_W-1:0] TERM_LIM = {TERM_MAG_W{1'b1}};
  localparam logic [DIV_D_W-1:0]    TICK_SCALE = 32'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP    = 3'd0,
    REG_GAIN_INTEG   = 3'd1,
    REG_GAIN_DERIV   = 3'd2,
    REG_FEED_FORWARD = 3'd3,
    REG_OUT_MIN      = 3'd4,
    REG_OUT_MAX      = 3'd5,
    REG_CLAMP_ENABLE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] target;
    logic        [DATA_W-1:0] timestamp_ms;
    logic                     restart;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     limited;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] mplier;
    logic [MUL_B_W-1:0] mcand;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DIV_N_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ hdl/pidc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pidc_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pidc_pkg::mul_req_t req_i,
  output pidc_pkg::mul_rsp_t rsp_o
);
  import pidc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_A_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_A_W - 1);

  logic [MUL_P_W-1:0] prod_q, prod_d;
  logic [MUL_B_W-1:0] mcand_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic [MUL_B_W:0]   part;

  always_comb begin
    part   = {1'b0, prod_q[MUL_P_W-1:MUL_A_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
    prod_d = {part, prod_q[MUL_A_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q  <= {{MUL_B_W{1'b0}}, req_i.mplier};
      mcand_q <= req_i.mcand;
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.prod = prod_q;

endmodule

@@ hdl/pidc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pidc_pkg::div_req_t req_i,
  output pidc_pkg::div_rsp_t rsp_o
);
  import pidc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_N_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N_W - 1);

  logic [DIV_D_W-1:0] rem_q, div_q;
  logic [DIV_N_W-1:0] quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic [DIV_D_W:0]   sh, dif;
  logic               ge;

  always_comb begin
    sh  = {rem_q, quo_q[DIV_N_W-1]};
    dif = sh - {1'b0, div_q};
    ge  = sh >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? dif[DIV_D_W-1:0] : sh[DIV_D_W-1:0];
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quo_q;

endmodule

@@ hdl/pid_controller_feedforward_clamp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_feedforward_clamp
// Fixed-point PID controller with signed feedforward and output clamp.
// The serial multiplier forms four products in turn, the first in parallel
// with the serial divider, and so sets the time from input accept to result valid.
// A new item is taken only when idle, so one item is finished before the next is taken.
// Reset clears history, marks the next item as first and loads register defaults.
// ----------------------------------------------------------------------------
module pid_controller_feedforward_clamp #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned ACCUM_WIDTH = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pidc_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pidc_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pidc_pkg::DATA_W-1:0]         cfg_data_i
);
  import pidc_pkg::*;

  localparam int unsigned AW  = ACCUM_WIDTH;
  localparam int unsigned SW  = 66;
  localparam int unsigned RW  = 44;
  localparam logic signed [SW-1:0] AMAX = (SW'(1) <<< (AW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] AMIN = -AMAX - SW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_RUN, S_INTEG, S_MP, S_MI, S_MD, S_SUM, S_OUT
  } state_e;

  state_e state_q;

  logic signed [DATA_W-1:0] kp_q, ki_q, kd_q, ff_q, omin_q, omax_q;
  logic                     clen_q;
  logic                     first_q;
  logic [DATA_W-1:0]        last_time_q;
  logic signed [DATA_W-1:0] last_err_q;
  logic signed [AW-1:0]     integ_q;

  in_item_t                 item_q;
  logic signed [DATA_W-1:0] e_q;
  logic                     de_neg_q, zdt_q, mneg_q, hit_q;
  logic signed [SW-2:0]     inc_q;
  logic signed [RW-1:0]     rate_q;
  logic signed [TERM_W-1:0] tp_q, ti_q, td_q;
  logic signed [63:0]       total_q;

  logic                     out_valid_q;
  out_item_t                out_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W-1:0] e_c, le_c;
  logic                     hist;
  logic [DATA_W-1:0]        lt_c, elapsed, abs_e;
  logic signed [DATA_W:0]   de_c;
  logic [DATA_W:0]          abs_de;
  logic                     zdt_c;
  logic [MUL_B_W-1:0]       inc_mag;
  logic [RW-2:0]            rate_mag;
  logic signed [SW-1:0]     isum;
  logic signed [AW-1:0]     isat;
  logic [AW-1:0]            abs_integ;
  logic [MUL_P_W-1:0]       tshift;
  logic                     tsat;
  logic [TERM_MAG_W-1:0]    tmag;
  logic signed [TERM_W-1:0] term_c;
  logic [DATA_W:0]          abs_ff;
  logic signed [DATA_W+1:0] kf;
  logic signed [DATA_W-1:0] v_c;
  logic                     vhit;

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
    return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  endfunction

  pidc_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));
  pidc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  always_comb begin
    diff = {item_q.target[DATA_W-1], item_q.target}
         - {item_q.position[DATA_W-1], item_q.position};
    if (diff[DATA_W] != diff[DATA_W-1])
      e_c = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    else
      e_c = diff[DATA_W-1:0];
    hist    = item_q.restart | first_q;
    lt_c    = hist ? item_q.timestamp_ms : last_time_q;
    le_c    = hist ? e_c : last_err_q;
    elapsed = item_q.timestamp_ms - lt_c;
    zdt_c   = elapsed == '0;
    de_c    = {e_c[DATA_W-1], e_c} - {le_c[DATA_W-1], le_c};
    abs_e   = mag32(e_c);
    abs_de  = de_c[DATA_W] ? (DATA_W+1)'(-de_c) : (DATA_W+1)'(de_c);

    inc_mag  = zdt_q ? MUL_B_W'(div_rsp.quot) : mul_rsp.prod[MUL_B_W-1:0];
    rate_mag = zdt_q ? mul_rsp.prod[RW-2:0] : (RW-1)'(div_rsp.quot);

    isum = SW'(integ_q) + SW'(inc_q);
    if (isum > AMAX)      isat = AW'(AMAX);
    else if (isum < AMIN) isat = AW'(AMIN);
    else                  isat = AW'(isum);
    abs_integ = integ_q[AW-1] ? AW'(-integ_q) : AW'(integ_q);

    tshift = mul_rsp.prod >> FRAC_BITS;
    tsat   = |tshift[MUL_P_W-1:TERM_MAG_W];
    tmag   = tsat ? TERM_LIM : tshift[TERM_MAG_W-1:0];
    term_c = mneg_q ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});

    abs_ff = ff_q[DATA_W-1] ? (DATA_W+1)'(-ff_q) : (DATA_W+1)'(ff_q);
    kf     = e_q[DATA_W-1] ? -$signed({1'b0, abs_ff}) : $signed({1'b0, abs_ff});

    vhit = 1'b0;
    if (total_q > 64'sh7FFFFFFF) begin
      v_c = {1'b0, {(DATA_W-1){1'b1}}};
      vhit = 1'b1;
    end else if (total_q < -64'sh80000000) begin
      v_c = {1'b1, {(DATA_W-1){1'b0}}};
      vhit = 1'b1;
    end else begin
      v_c = DATA_W'(total_q);
    end
    if (clen_q) begin
      if (v_c > omax_q) begin
        v_c = omax_q;
        vhit = 1'b1;
      end else if (v_c < omin_q) begin
        v_c = omin_q;
        vhit = 1'b1;
      end
    end
  end

  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state_q)
      S_PREP: begin
        mul_req.start    = 1'b1;
        mul_req.mplier   = zdt_c ? TICK_SCALE : elapsed;
        mul_req.mcand    = zdt_c ? MUL_B_W'(abs_de) : MUL_B_W'(abs_e);
        div_req.start    = 1'b1;
        div_req.dividend = zdt_c ? DIV_N_W'(abs_e) : DIV_N_W'(abs_de);
        div_req.divisor  = zdt_c ? TICK_SCALE : elapsed;
      end
      S_INTEG: begin
        mul_req.start  = 1'b1;
        mul_req.mplier = mag32(kp_q);
        mul_req.mcand  = MUL_B_W'(mag32(e_q));
      end
      S_MP: begin
        mul_req.start  = !mul_rsp.busy;
        mul_req.mplier = mag32(ki_q);
        mul_req.mcand  = MUL_B_W'(abs_integ);
      end
      S_MI: begin
        mul_req.start  = !mul_rsp.busy;
        mul_req.mplier = mag32(kd_q);
        mul_req.mcand  = MUL_B_W'(rate_q[RW-1] ? RW'(-rate_q) : RW'(rate_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      ff_q        <= '0;
      omin_q      <= {1'b1, {(DATA_W-1){1'b0}}};
      omax_q      <= {1'b0, {(DATA_W-1){1'b1}}};
      clen_q      <= 1'b0;
      first_q     <= 1'b1;
      last_time_q <= '0;
      last_err_q  <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_GAIN_PROP:    kp_q   <= cfg_data_i;
          REG_GAIN_INTEG:   ki_q   <= cfg_data_i;
          REG_GAIN_DERIV:   kd_q   <= cfg_data_i;
          REG_FEED_FORWARD: ff_q   <= cfg_data_i;
          REG_OUT_MIN:      omin_q <= cfg_data_i;
          REG_OUT_MAX:      omax_q <= cfg_data_i;
          REG_CLAMP_ENABLE: clen_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            hit_q   <= 1'b0;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          e_q         <= e_c;
          de_neg_q    <= de_c[DATA_W];
          zdt_q       <= zdt_c;
          first_q     <= 1'b0;
          last_time_q <= item_q.timestamp_ms;
          last_err_q  <= e_c;
          if (hist) integ_q <= '0;
          state_q     <= S_RUN;
        end
        S_RUN: begin
          if (!mul_rsp.busy && !div_rsp.busy) begin
            inc_q   <= e_q[DATA_W-1] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
            rate_q  <= de_neg_q ? -$signed({1'b0, rate_mag}) : $signed({1'b0, rate_mag});
            state_q <= S_INTEG;
          end
        end
        S_INTEG: begin
          integ_q <= isat;
          mneg_q  <= kp_q[DATA_W-1] ^ e_q[DATA_W-1];
          state_q <= S_MP;
        end
        S_MP: begin
          if (!mul_rsp.busy) begin
            tp_q    <= term_c;
            hit_q   <= hit_q | tsat;
            mneg_q  <= ki_q[DATA_W-1] ^ integ_q[AW-1];
            state_q <= S_MI;
          end
        end
        S_MI: begin
          if (!mul_rsp.busy) begin
            ti_q    <= term_c;
            hit_q   <= hit_q | tsat;
            mneg_q  <= kd_q[DATA_W-1] ^ rate_q[RW-1];
            state_q <= S_MD;
          end
        end
        S_MD: begin
          if (!mul_rsp.busy) begin
            td_q    <= term_c;
            hit_q   <= hit_q | tsat;
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          total_q <= 64'(tp_q) + 64'(ti_q) + 64'(td_q) + 64'(kf);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.drive   <= v_c;
            out_q.limited <= hit_q | vhit;
            out_valid_q   <= 1'b1;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hdl/pidc_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_chk
// Port-level checks for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidc_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input pidc_pkg::out_item_t            out_item_o
);
  import pidc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after an accepted item");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after an item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind pid_controller_feedforward_clamp pidc_chk u_pidc_chk (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the PID controller with feedforward and clamp against a cycle-free
// predictor. Directed samples hit error saturation, zero elapsed time,
// timestamp wrap, restart and zero error. Random sample streams then run
// under several gain and clamp settings, with random idling on both sides,
// a long output hold-off and drain pauses between settings.
// ----------------------------------------------------------------------------
module testbench;
  import pidc_pkg::*;

  localparam int NUM_RANDOM = 1680;
  localparam longint TERM_MAX = (64'sd1 <<< 60) - 1;
  localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -S32_MAX - 1;

  class pid_scoreboard;
    longint gain_p, gain_i, gain_d, feed_fwd, lim_lo, lim_hi;
    bit clamp_on, first_seen, sat_hit;
    logic [31:0] prev_time;
    longint prev_err, integ;
    out_item_t expected_drive[$];
    int mismatches, checked, limited_seen;

    function new();
      gain_p = 0; gain_i = 0; gain_d = 0; feed_fwd = 0;
      lim_lo = S32_MIN; lim_hi = S32_MAX; clamp_on = 0;
      first_seen = 1; prev_time = 0; prev_err = 0; integ = 0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [31:0] d);
      case (r)
        REG_GAIN_PROP:    gain_p = longint'($signed(d));
        REG_GAIN_INTEG:   gain_i = longint'($signed(d));
        REG_GAIN_DERIV:   gain_d = longint'($signed(d));
        REG_FEED_FORWARD: feed_fwd = longint'($signed(d));
        REG_OUT_MIN:      lim_lo = longint'($signed(d));
        REG_OUT_MAX:      lim_hi = longint'($signed(d));
        REG_CLAMP_ENABLE: clamp_on = d[0];
        default: ;
      endcase
    endfunction

    function longint gain_term(longint a, longint b);
      logic [63:0] ma, mb;
      logic [127:0] t;
      bit neg;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      t = ({64'b0, ma} * {64'b0, mb}) >> 16;
      if (t > TERM_MAX) begin
        t = TERM_MAX;
        sat_hit = 1;
      end
      return neg ? -longint'(t[63:0]) : longint'(t[63:0]);
    endfunction

    function void add_sample(in_item_t it);
      longint e, de, inc, rate, kf, sum, v, dt;
      logic [31:0] elapsed;
      e = longint'($signed(it.target)) - longint'($signed(it.position));
      if (e > S32_MAX) e = S32_MAX;
      if (e < S32_MIN) e = S32_MIN;
      if (it.restart || first_seen) begin
        prev_time = it.timestamp_ms;
        prev_err = e;
        integ = 0;
        first_seen = 0;
      end
      elapsed = it.timestamp_ms - prev_time;
      dt = longint'({32'b0, elapsed});
      de = e - prev_err;
      if (elapsed == 0) begin
        inc = e / 1000;
        rate = de * 1000;
      end else begin
        inc = e * dt;
        rate = de / dt;
      end
      if (inc > 0 && integ > ACC_MAX - inc) integ = ACC_MAX;
      else if (inc < 0 && integ < ACC_MIN - inc) integ = ACC_MIN;
      else integ = integ + inc;
      kf = (feed_fwd < 0) ? -feed_fwd : feed_fwd;
      if (e < 0) kf = -kf;
      sat_hit = 0;
      sum = gain_term(gain_p, e) + gain_term(gain_i, integ) + gain_term(gain_d, rate) + kf;
      v = sum;
      if (v > S32_MAX) begin
        v = S32_MAX;
        sat_hit = 1;
      end else if (v < S32_MIN) begin
        v = S32_MIN;
        sat_hit = 1;
      end
      if (clamp_on) begin
        if (v > lim_hi) begin
          v = lim_hi;
          sat_hit = 1;
        end else if (v < lim_lo) begin
          v = lim_lo;
          sat_hit = 1;
        end
      end
      prev_time = it.timestamp_ms;
      prev_err = e;
      expected_drive.push_back('{drive: v[31:0], limited: sat_hit});
    endfunction

    function void check_drive(out_item_t got);
      out_item_t want;
      if (expected_drive.size() == 0) begin
        $display("%0t: unexpected result drive=%h limited=%b", $time, got.drive, got.limited);
        mismatches++;
        return;
      end
      want = expected_drive.pop_front();
      checked++;
      if (got.limited) limited_seen++;
      if (got.drive !== want.drive) begin
        $display("%0t: drive expected %h actual %h", $time, want.drive, got.drive);
        mismatches++;
      end
      if (got.limited !== want.limited) begin
        $display("%0t: limited expected %b actual %b", $time, want.limited, got.limited);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_item_t in_item_i;
  out_item_t out_item_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0] cfg_data_i;

  pid_scoreboard sb;
  int tx_idle, rx_idle, hold_cycles, sent;
  logic [31:0] clock_ms;

  pid_controller_feedforward_clamp dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_drive(out_item_o);
  end

  task automatic write_reg(cfg_reg_e r, logic [31:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_reg(r, d);
  endtask

  task automatic load_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                            logic [31:0] ff, logic [31:0] lo, logic [31:0] hi, bit en);
    in_valid_i <= 1'b0;
    while (sb.expected_drive.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    write_reg(REG_GAIN_PROP, kp);
    write_reg(REG_GAIN_INTEG, ki);
    write_reg(REG_GAIN_DERIV, kd);
    write_reg(REG_FEED_FORWARD, ff);
    write_reg(REG_OUT_MIN, lo);
    write_reg(REG_OUT_MAX, hi);
    write_reg(REG_CLAMP_ENABLE, {31'b0, en});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_sample(logic [31:0] pos, logic [31:0] tgt, logic [31:0] ts, bit rs);
    if ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{position: pos, target: tgt, timestamp_ms: ts, restart: rs};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.add_sample(in_item_i);
    sent++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3:       return {1'($urandom_range(1)), {31{$urandom_range(1) == 1}}};
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  initial begin
    logic [31:0] lo, hi;
    sb = new();
    tx_idle = 20;
    rx_idle = 71;
    hold_cycles = 0;
    sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_gains(32'h0001_0000, 32'h0000_0100, 32'h0000_8000, 32'hFFFF_8000,
               32'hFFF0_0000, 32'h0010_0000, 1'b1);
    send_sample(32'h0001_0000, 32'h0003_0000, 32'd100, 1'b0);
    send_sample(32'h0001_0000, 32'h0003_0000, 32'd100, 1'b0);
    send_sample(32'h0002_0000, 32'h0002_0000, 32'd105, 1'b0);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd106, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd106, 1'b0);
    send_sample(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFF0, 1'b1);
    send_sample(32'h0000_1000, 32'h0000_0000, 32'h0000_0010, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0010, 1'b0);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0010, 1'b0);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0010, 1'b0);
    send_sample(32'h1234_5678, 32'h1234_5678, 32'd7, 1'b1);
    send_sample(32'h0000_0000, 32'h0000_03E7, 32'd7, 1'b0);
    send_sample(32'h0000_0000, 32'hFFFF_FC19, 32'd8, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    load_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b0);
    send_sample(32'h0000_0000, 32'h0000_0000, 32'd2, 1'b0);
    load_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h0001_0000, 32'hFFFF_0000, 1'b1);
    send_sample(32'h0000_0000, 32'h0000_0000, 32'd10, 1'b1);
    send_sample(32'h0004_0000, 32'h0000_0000, 32'd12, 1'b0);
    send_sample(32'h0000_0000, 32'h0000_8000, 32'd12, 1'b0);

    clock_ms = $urandom;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 3) begin
        tx_idle = 71;
        rx_idle = 20;
      end else if (i == 2 * NUM_RANDOM / 3) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (i % 280 == 0) begin
        lo = pick_value();
        hi = pick_value();
        if (i == 560) begin
          load_gains(32'h0, 32'h0, 32'h0, pick_value(), lo, hi, 1'b1);
        end else begin
          load_gains(pick_gain(), pick_gain(), pick_gain(), pick_value(),
                     ($signed(lo) < $signed(hi) || i == 840) ? lo : hi,
                     ($signed(lo) < $signed(hi) || i == 840) ? hi : lo,
                     1'($urandom_range(1)));
        end
        if (i == 280) hold_cycles = 600;
      end
      case ($urandom_range(19))
        0:       clock_ms = $urandom;
        1, 2:    ;
        default: clock_ms = clock_ms + $urandom_range(1, 30);
      endcase
      send_sample(pick_value(), pick_value(), clock_ms, $urandom_range(19) == 0);
    end
    in_valid_i <= 1'b0;

    while (sb.expected_drive.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d samples under nine gain settings; checked %0d results, %0d limited.",
             sent, sb.checked, sb.limited_seen);
    if (sb.mismatches == 0 && sb.expected_drive.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
